// File: rtl/sha_pkg.sv
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LengthPos  = 56;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned DigestWords = 8;

  localparam logic       OpAbsorb = 1'b0;
  localparam logic       OpFinish = 1'b1;
  localparam logic [7:0] PadByte  = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t InitHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // Byte-lane commands from the controller to the datapath.
  typedef enum logic [2:0] {
    BufNone,
    BufData,
    BufPad,
    BufZero,
    BufLen
  } buf_op_e;

  typedef struct packed {
    buf_op_e    buf_op;
    logic [5:0] buf_addr;
    logic [7:0] data;
    logic       count_byte;   // add eight to the bit count
    logic       comp_start;   // begin a compression
    logic       init_msg;     // reload hash and clear bit count
    logic [2:0] out_idx;      // digest word to present
  } sha_cmd_t;

  typedef struct packed {
    logic comp_busy;
  } sha_sts_t;

  function automatic word_t ror(input word_t v, input int unsigned n);
    ror = (v >> n) | (v << (32 - n));
  endfunction

endpackage

// File: rtl/sha_ram.sv
module sha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/sha_datapath.sv
module sha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::sha_cmd_t cmd_i,
  output sha_pkg::sha_sts_t sts_o,
  output sha_pkg::word_t    digest_o
);

  typedef enum logic [1:0] {
    CIdle,
    CLoad,
    CRound,
    CAdd
  } comp_e;

  comp_e           cst_q;
  logic [6:0]      cnt_q;      // load: byte count, round: round number
  sha_pkg::word_t  h_q [8];
  sha_pkg::word_t  s_q [8];
  sha_pkg::word_t  w_q [16];
  logic [63:0]     bits_q;
  logic [5:0]      raddr;
  logic [7:0]      rdata;
  logic            we;
  logic [7:0]      wdata;

  always_comb begin
    case (cmd_i.buf_op)
      sha_pkg::BufData: wdata = cmd_i.data;
      sha_pkg::BufPad:  wdata = sha_pkg::PadByte;
      sha_pkg::BufLen:  wdata = bits_q[8*(7-cmd_i.buf_addr[2:0]) +: 8];
      default:          wdata = 8'h00;
    endcase
  end
  assign we = (cmd_i.buf_op != sha_pkg::BufNone);
  assign raddr = cnt_q[5:0];

  sha_ram #(.Width(8), .Depth(sha_pkg::BlockBytes)) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cmd_i.buf_addr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Round logic
  sha_pkg::word_t wt, w15, w2, sg0, sg1, wnew, t1, t2, e, a;
  always_comb begin
    w15  = w_q[1];
    w2   = w_q[14];
    sg0  = sha_pkg::ror(w15, 7) ^ sha_pkg::ror(w15, 18) ^ (w15 >> 3);
    sg1  = sha_pkg::ror(w2, 17) ^ sha_pkg::ror(w2, 19) ^ (w2 >> 10);
    wnew = w_q[0] + sg0 + w_q[9] + sg1;
    wt   = w_q[0];
    e    = s_q[4];
    a    = s_q[0];
    t1   = s_q[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
         + ((e & s_q[5]) ^ (~e & s_q[6])) + sha_pkg::RoundK[cnt_q[5:0]] + wt;
    t2   = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
         + ((a & s_q[1]) ^ (a & s_q[2]) ^ (s_q[1] & s_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q  <= CIdle;
      cnt_q  <= '0;
      bits_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
    end else begin
      if (cmd_i.count_byte) bits_q <= bits_q + 64'd8;
      if (cmd_i.init_msg) begin
        bits_q <= '0;
        for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
      end
      case (cst_q)
        CIdle: begin
          if (cmd_i.comp_start) begin
            cst_q <= CLoad;
            cnt_q <= 7'd1;
          end
        end
        CLoad: begin
          // The read data is registered behind the address; shift bytes into the
          // schedule window, which after 64 bytes holds words 0 to 15.
          for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
          w_q[15] <= {w_q[15][23:0], rdata};
          if (cnt_q == 7'd64) begin
            cst_q <= CRound;
            cnt_q <= '0;
            for (int i = 0; i < 8; i++) s_q[i] <= h_q[i];
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        CRound: begin
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wnew;
          s_q[7] <= s_q[6];
          s_q[6] <= s_q[5];
          s_q[5] <= s_q[4];
          s_q[4] <= s_q[3] + t1;
          s_q[3] <= s_q[2];
          s_q[2] <= s_q[1];
          s_q[1] <= s_q[0];
          s_q[0] <= t1 + t2;
          if (cnt_q == 7'd63) cst_q <= CAdd;
          cnt_q <= cnt_q + 7'd1;
        end
        CAdd: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + s_q[i];
          cst_q <= CIdle;
          cnt_q <= '0;
        end
        default: cst_q <= CIdle;
      endcase
    end
  end

  assign sts_o.comp_busy = (cst_q != CIdle);
  assign digest_o = h_q[cmd_i.out_idx];

endmodule

// File: rtl/sha_ctrl.sv
module sha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_op_i,
  input  logic [7:0]        in_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        out_idx_o,
  output sha_pkg::sha_cmd_t cmd_o,
  input  sha_pkg::sha_sts_t sts_i
);

  typedef enum logic [2:0] {
    SIdle,
    SWait,
    SPadZero,
    SLenZero,
    SLenWrite,
    SFinWait,
    SEmit
  } state_e;

  state_e     state_q;
  logic [6:0] fill_q;
  logic [2:0] idx_q;

  wire acc  = in_valid_i && in_ready_o;
  wire busy = sts_i.comp_busy;

  assign in_ready_o  = (state_q == SIdle) && !busy;
  assign out_valid_o = (state_q == SEmit);
  assign out_idx_o   = idx_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.buf_op = sha_pkg::BufNone;
    cmd_o.buf_addr = fill_q[5:0];
    cmd_o.data = in_byte_i;
    cmd_o.out_idx = idx_q;
    case (state_q)
      SIdle: begin
        if (acc) begin
          cmd_o.buf_op = (in_op_i == sha_pkg::OpAbsorb) ? sha_pkg::BufData : sha_pkg::BufPad;
          cmd_o.count_byte = (in_op_i == sha_pkg::OpAbsorb);
          // A data byte or a pad byte in the last slot closes the block.
          cmd_o.comp_start = (fill_q == 7'd63);
        end
      end
      SPadZero: begin
        if (!busy) begin
          cmd_o.buf_op = sha_pkg::BufZero;
          cmd_o.comp_start = (fill_q == 7'd63);
        end
      end
      SLenZero: if (!busy) cmd_o.buf_op = sha_pkg::BufZero;
      SLenWrite: begin
        if (!busy) begin
          cmd_o.buf_op = sha_pkg::BufLen;
          cmd_o.comp_start = (fill_q == 7'd63);
        end
      end
      SEmit: cmd_o.init_msg = out_ready_i && (idx_q == 3'd7);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      fill_q  <= '0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        SIdle: begin
          if (acc) begin
            if (in_op_i == sha_pkg::OpAbsorb) begin
              fill_q <= (fill_q == 7'd63) ? 7'd0 : fill_q + 7'd1;
            end else begin
              fill_q <= fill_q + 7'd1;
              if (fill_q + 7'd1 > 7'(sha_pkg::LengthPos)) state_q <= SPadZero;
              else state_q <= SLenZero;
            end
          end
        end
        SPadZero: begin
          if (!busy) begin
            if (fill_q == 7'd64) begin
              fill_q  <= '0;
              state_q <= SLenZero;
            end else begin
              fill_q <= fill_q + 7'd1;
            end
          end
        end
        SLenZero: begin
          if (!busy) begin
            if (fill_q >= 7'(sha_pkg::LengthPos)) begin
              fill_q  <= 7'(sha_pkg::LengthPos);
              state_q <= SLenWrite;
            end else begin
              fill_q <= fill_q + 7'd1;
            end
          end
        end
        SLenWrite: begin
          if (!busy) begin
            fill_q <= fill_q + 7'd1;
            if (fill_q == 7'd63) begin
              state_q <= SFinWait;
            end
          end
        end
        SFinWait: begin
          if (!busy) begin
            fill_q  <= '0;
            idx_q   <= '0;
            state_q <= SEmit;
          end
        end
        SEmit: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

// File: rtl/sha256_byte_stream_hasher_top.sv
// SHA-256 hasher over a byte stream.
// Slave channel: each word carries an opcode in s_axis_tuser (0 absorb the
// byte in s_axis_tdata, 1 finish the message). Master channel: on finish the
// eight digest words leave most significant first, with the word index in
// m_axis_tuser and m_axis_tlast on the eighth.
// The 64th byte of a block starts a compression that holds s_axis_tready
// low while the block loads from the buffer RAM through its single read
// port, the 64 rounds of the shared round unit run and the add step
// folds the result into the hash.
// A finish writes the pad byte, the zero fill and the eight length bytes one
// per cycle while no compression runs, up to the end of the block, and then
// compresses; when more than 55 bytes were pending, the first block is
// closed with zeros and compressed before the length block is written.
// Once the last compression is done, the eight digest words follow, one per
// accepted cycle. Reset restores the initial hash, empties the buffer count
// and clears the bit count. When the receiver stalls, the current digest
// word holds and no input is taken until all eight words are delivered.
module sha256_byte_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_index
  output logic        m_axis_tlast    // last_word
);

  sha_pkg::sha_cmd_t cmd;
  sha_pkg::sha_sts_t sts;
  logic [2:0]        idx;

  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_idx_o   (idx),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sha_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .digest_o (m_axis_tdata)
  );

  assign m_axis_tuser = idx;
  assign m_axis_tlast = (idx == 3'd7);

`ifndef NO_ASSERTIONS
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during digest output");
  a_last_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output continued past last word");
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.comp_busy |-> !s_axis_tready) else $error("input taken during compression");
`endif

endmodule
